// ===== rtl/eds_pkg.sv =====
// Shared types and constants for the elevator SCAN scheduler.
// Depends on nothing; every other file in rtl refers to it by scoped names.
`default_nettype none

package eds_pkg;

    localparam int FLOOR_W  = 6;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int RIDERS_W = 8;
    // Wide enough to compare a 6-bit floor count against a limit of up to 64.
    localparam int LIM_W    = FLOOR_W + 1;

    localparam int MAX_RESULTS = 32;
    localparam int STOP_CNT_W  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FLOOR_W-1:0] NUM_FLOORS_RST = 6'd32;

    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SWEEP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ENTER   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_STOP = 2'd2;

    typedef enum logic [2:0] {
        OP_REQUEST,
        OP_IGNORE,
        OP_SWEEP,
        OP_ENTER,
        OP_EXIT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [FLOOR_W-1:0] floor;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/eds_front.sv =====
// Front end of the scheduler: takes requests on the command port and classifies them.
// Depends on eds_pkg; feeds eds_queue.
`default_nettype none

module eds_front (
    input  wire logic                         start,
    input  wire logic [eds_pkg::MODE_W-1:0]   mode,
    input  wire logic [eds_pkg::FLOOR_W-1:0]  floor,
    input  wire logic [eds_pkg::LIM_W-1:0]    limit,
    input  wire logic                         queue_full,
    output logic                              busy,
    output logic                              push,
    output eds_pkg::cmd_t                     cmd
);

    logic floor_ok;

    // A floor request is only kept when the floor is in use; otherwise it is
    // still acknowledged but changes nothing.
    assign floor_ok = (floor != '0) && ({1'b0, floor} <= limit);

    always_comb
    begin
        cmd.floor = floor;
        case (mode)
            eds_pkg::MODE_REQUEST: cmd.op = floor_ok ? eds_pkg::OP_REQUEST : eds_pkg::OP_IGNORE;
            eds_pkg::MODE_SWEEP:   cmd.op = eds_pkg::OP_SWEEP;
            eds_pkg::MODE_ENTER:   cmd.op = eds_pkg::OP_ENTER;
            eds_pkg::MODE_EXIT:    cmd.op = eds_pkg::OP_EXIT;
            default:               cmd.op = eds_pkg::OP_IGNORE;
        endcase
    end

    assign busy = queue_full;
    assign push = start & ~queue_full;

endmodule

`default_nettype wire

// ===== rtl/eds_queue.sv =====
// Short command queue between the front end and the execution back end.
// Depends on eds_pkg for the command type and the queue depth.
`default_nettype none

module eds_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire eds_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output eds_pkg::cmd_t       head_cmd,
    output logic                empty,
    output logic                full
);

    localparam int PTR_W = $clog2(eds_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(eds_pkg::QUEUE_DEPTH + 1);

    eds_pkg::cmd_t entry_reg [eds_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CNT_W'(eds_pkg::QUEUE_DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(eds_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(eds_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/eds_back.sv =====
// Back end of the scheduler: holds the floor bitmap, car position, direction and
// rider count, and carries out queued commands. Depends on eds_pkg.
`default_nettype none

module eds_back #(
    parameter int MAX_FLOORS = 32,
    parameter int MAX_RIDERS = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [eds_pkg::LIM_W-1:0]     limit,
    input  wire logic                          queue_empty,
    input  wire eds_pkg::cmd_t                 head_cmd,
    output logic                               pop,
    output logic                               result_strobe,
    output logic [eds_pkg::KIND_W-1:0]         kind,
    output logic [eds_pkg::FLOOR_W-1:0]        arrived_floor,
    output logic                               last,
    output logic                               pending,
    output logic [eds_pkg::RIDERS_W-1:0]       riders,
    output logic                               going_up
);

    localparam int CUR_W = $clog2(MAX_FLOORS + 1);
    localparam int IDX_W = $clog2(MAX_FLOORS);
    localparam int RID_W = $clog2(MAX_RIDERS + 1);
    localparam int LW    = eds_pkg::LIM_W;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    state_t                              state_reg, state_next;
    logic [MAX_FLOORS-1:0]               req_reg, req_next;
    logic [CUR_W-1:0]                    cur_reg, cur_next;
    logic                                dir_up_reg, dir_up_next;
    logic                                sweep_up_reg, sweep_up_next;
    logic [RID_W-1:0]                    rid_reg, rid_next;
    logic [eds_pkg::STOP_CNT_W-1:0]      stops_reg, stops_next;

    logic                                strobe_next;
    logic [eds_pkg::KIND_W-1:0]          kind_next;
    logic                                last_next;

    logic [MAX_FLOORS-1:0]               vis_mask;
    logic [MAX_FLOORS-1:0]               beyond;
    logic [MAX_FLOORS-1:0]               cand;
    logic [MAX_FLOORS-1:0]               cand_rev;
    logic [MAX_FLOORS-1:0]               low_rev;
    logic [MAX_FLOORS-1:0]               low_up;
    logic [MAX_FLOORS-1:0]               stop_hot;
    logic [IDX_W-1:0]                    stop_idx;
    logic                                more_stops;
    logic [eds_pkg::FLOOR_W-1:0]         req_idx;
    logic [LW-1:0]                       cur_wide;
    logic [LW-1:0]                       cur_wide_next;
    logic [RID_W+eds_pkg::RIDERS_W-1:0]  rid_wide;

    assign cur_wide = LW'(cur_reg);
    assign req_idx  = head_cmd.floor - 1'b1;

    // Floors above the limit keep their marks but are neither served nor pending.
    always_comb
    begin
        for (int i = 0; i < MAX_FLOORS; i++)
        begin
            vis_mask[i] = (LW'(i) < limit);
            if (sweep_up_reg)
            begin
                beyond[i] = (LW'(i) >= cur_wide);
            end
            else
            begin
                beyond[i] = (LW'(i + 1) < cur_wide);
            end
        end
    end

    assign cand = req_reg & vis_mask & beyond;

    // Nearest stop in the travel direction: the lowest candidate going up, the
    // highest going down (found as the lowest of the bit-reversed vector).
    always_comb
    begin
        for (int i = 0; i < MAX_FLOORS; i++)
        begin
            cand_rev[i] = cand[MAX_FLOORS - 1 - i];
        end
    end

    assign low_up  = cand & (~cand + 1'b1);
    assign low_rev = cand_rev & (~cand_rev + 1'b1);

    always_comb
    begin
        stop_idx = '0;
        for (int i = 0; i < MAX_FLOORS; i++)
        begin
            stop_hot[i] = sweep_up_reg ? low_up[i] : low_rev[MAX_FLOORS - 1 - i];
        end
        for (int i = 0; i < MAX_FLOORS; i++)
        begin
            if (stop_hot[i])
            begin
                stop_idx = stop_idx | IDX_W'(i);
            end
        end
    end

    assign more_stops = (|(cand & ~stop_hot))
                        && (stops_reg < eds_pkg::STOP_CNT_W'(eds_pkg::MAX_RESULTS - 1));

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cur_next      = cur_reg;
        dir_up_next   = dir_up_reg;
        sweep_up_next = sweep_up_reg;
        rid_next      = rid_reg;
        stops_next    = stops_reg;
        strobe_next   = 1'b0;
        kind_next     = eds_pkg::KIND_ACK;
        last_next     = 1'b1;
        pop           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    case (head_cmd.op)
                        eds_pkg::OP_REQUEST:
                        begin
                            strobe_next = 1'b1;
                            for (int i = 0; i < MAX_FLOORS; i++)
                            begin
                                if (eds_pkg::FLOOR_W'(i) == req_idx)
                                begin
                                    req_next[i] = 1'b1;
                                end
                            end
                        end
                        eds_pkg::OP_ENTER:
                        begin
                            strobe_next = 1'b1;
                            if (rid_reg < RID_W'(MAX_RIDERS))
                            begin
                                rid_next = rid_reg + 1'b1;
                            end
                        end
                        eds_pkg::OP_EXIT:
                        begin
                            strobe_next = 1'b1;
                            if (rid_reg != '0)
                            begin
                                rid_next = rid_reg - 1'b1;
                            end
                        end
                        eds_pkg::OP_SWEEP:
                        begin
                            sweep_up_next = dir_up_reg;
                            dir_up_next   = ~dir_up_reg;
                            stops_next    = '0;
                            state_next    = ST_SWEEP;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                strobe_next = 1'b1;
                if (cand == '0)
                begin
                    kind_next  = eds_pkg::KIND_NO_STOP;
                    state_next = ST_IDLE;
                end
                else
                begin
                    kind_next  = eds_pkg::KIND_ARRIVAL;
                    req_next   = req_reg & ~stop_hot;
                    cur_next   = CUR_W'(stop_idx) + CUR_W'(1);
                    stops_next = stops_reg + 1'b1;
                    last_next  = ~more_stops;
                    if (!more_stops)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cur_wide_next = LW'(cur_next);
    assign rid_wide      = {eds_pkg::RIDERS_W'(0), rid_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            cur_reg       <= CUR_W'(1);
            dir_up_reg    <= 1'b1;
            sweep_up_reg  <= 1'b1;
            rid_reg       <= '0;
            stops_reg     <= '0;
            result_strobe <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            cur_reg       <= cur_next;
            dir_up_reg    <= dir_up_next;
            sweep_up_reg  <= sweep_up_next;
            rid_reg       <= rid_next;
            stops_reg     <= stops_next;
            result_strobe <= strobe_next;
        end
    end

    // Result payload; only meaningful while the strobe is high.
    always_ff @(posedge clk)
    begin
        kind          <= kind_next;
        arrived_floor <= cur_wide_next[eds_pkg::FLOOR_W-1:0];
        last          <= last_next;
        pending       <= |(req_next & vis_mask);
        riders        <= rid_wide[eds_pkg::RIDERS_W-1:0];
        going_up      <= dir_up_next;
    end

endmodule

`default_nettype wire

// ===== rtl/elevator_scan_scheduler_top.sv =====
// Top level of the elevator SCAN scheduler: floor-count register, front end,
// command queue and back end. Depends on eds_pkg, eds_front, eds_queue and eds_back.
//
//   Channel   Handshake                Payload
//   command   start / busy             mode, floor
//   result    result_strobe (1 cycle)  kind, arrived_floor, last, pending, riders, going_up
//   config    cfg_we                   cfg_data (num_floors)
//
// A command enters the queue on the edge where start is high and busy is low; busy is
// high only while the two-entry queue is full. The back end takes one queued command at
// a time: a request, enter or exit gives a registered result once popped; a sweep enters
// the sweep state and gives one arrival a cycle from the priority encoder over the floor
// bitmap, or one no-stop result if no floor is marked. Results cannot be held off by the
// receiver. Reset is asynchronous and clears all control state; there is no clearing pass.
`default_nettype none

module elevator_scan_scheduler_top #(
    parameter int MAX_FLOORS = 32,
    parameter int MAX_RIDERS = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [eds_pkg::MODE_W-1:0]    mode,
    input  wire logic [eds_pkg::FLOOR_W-1:0]   floor,
    input  wire logic                          cfg_we,
    input  wire logic [eds_pkg::FLOOR_W-1:0]   cfg_data,
    output logic                               result_strobe,
    output logic [eds_pkg::KIND_W-1:0]         kind,
    output logic [eds_pkg::FLOOR_W-1:0]        arrived_floor,
    output logic                               last,
    output logic                               pending,
    output logic [eds_pkg::RIDERS_W-1:0]       riders,
    output logic                               going_up
);

    localparam int LW = eds_pkg::LIM_W;

    logic [eds_pkg::FLOOR_W-1:0] num_floors_reg;
    logic [LW-1:0]               nf_wide;
    logic [LW-1:0]               limit;
    logic                        push;
    logic                        pop;
    logic                        queue_empty;
    logic                        queue_full;
    eds_pkg::cmd_t               push_cmd;
    eds_pkg::cmd_t               head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_floors_reg <= eds_pkg::NUM_FLOORS_RST;
        end
        else if (cfg_we)
        begin
            num_floors_reg <= cfg_data;
        end
    end

    assign nf_wide = LW'(num_floors_reg);
    assign limit   = (nf_wide > LW'(MAX_FLOORS)) ? LW'(MAX_FLOORS) : nf_wide;

    eds_front u_front (
        .start      (start),
        .mode       (mode),
        .floor      (floor),
        .limit      (limit),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    eds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    eds_back #(
        .MAX_FLOORS (MAX_FLOORS),
        .MAX_RIDERS (MAX_RIDERS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .limit         (limit),
        .queue_empty   (queue_empty),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .result_strobe (result_strobe),
        .kind          (kind),
        .arrived_floor (arrived_floor),
        .last          (last),
        .pending       (pending),
        .riders        (riders),
        .going_up      (going_up)
    );

endmodule

`default_nettype wire

// ===== rtl/eds_checker.sv =====
// Port-level checks for the elevator SCAN scheduler, bound to the top level.
// Depends on eds_pkg for the result kind codes.
`default_nettype none

module eds_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          result_strobe,
    input wire logic [eds_pkg::KIND_W-1:0]    kind,
    input wire logic                          last,
    input wire logic                          going_up
);

    // Only arrivals can be followed by further results of the same request.
    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (kind != eds_pkg::KIND_ARRIVAL) |-> last)
        else $error("acknowledge or no-stop result without last");

    // A sweep that has more stops delivers the next arrival in the very next cycle.
    a_arrivals_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |=> result_strobe && (kind == eds_pkg::KIND_ARRIVAL))
        else $error("arrival train broken before its last result");

    // The direction flips once at the start of a sweep and holds across its arrivals.
    a_direction_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |=> $stable(going_up))
        else $error("direction changed within one sweep");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (kind == eds_pkg::KIND_ACK) || (kind == eds_pkg::KIND_ARRIVAL)
                          || (kind == eds_pkg::KIND_NO_STOP))
        else $error("undefined result kind");

endmodule

bind elevator_scan_scheduler_top eds_checker u_eds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_strobe (result_strobe),
    .kind          (kind),
    .last          (last),
    .going_up      (going_up)
);

`default_nettype wire
